@@ hdl/kwm_pkg.sv @@
// kwm_pkg: shared constants, types and functions of the k-mer window minimizer.
// No dependencies.
`default_nettype none
package kwm_pkg;
  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned MAX_KMER_DEF   = 32;
  localparam int unsigned POS_BITS_DEF   = 32;

  localparam logic [2:0] CODE_N = 3'd4;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_KMER    = 2'd1;
  localparam logic [1:0] REG_LARGEST = 2'd2;

  localparam logic RESULT_POS   = 1'b0;
  localparam logic RESULT_COUNT = 1'b1;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic       has_base;
    logic [2:0] code;
    logic       last;
  } kwm_item_t;

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    begin
      unique case (c)
        8'h41, 8'h61: r = 3'd0;
        8'h43, 8'h63: r = 3'd1;
        8'h47, 8'h67: r = 3'd2;
        8'h54, 8'h74, 8'h55, 8'h75: r = 3'd3;
        default: r = CODE_N;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

@@ hdl/kwm_front.sv @@
// kwm_front: accepts characters, classifies them and queues them for the back.
// Depends on kwm_pkg.
`default_nettype none
module kwm_front import kwm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       flush,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_byte,
  input  wire logic       seq_end,
  output logic            q_valid,
  input  wire logic       q_ready,
  output kwm_item_t       q_item
);
  // two-entry queue
  kwm_item_t slot [2];
  logic      rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;
  kwm_item_t item_in;

  always_comb begin
    item_in.has_base = (char_byte > SPACE_CHAR);
    item_in.code     = base_code(char_byte);
    item_in.last     = seq_end;
  end

  assign in_ready = (fill != 2'd2) && !flush;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end
endmodule
`default_nettype wire

@@ hdl/kwm_back.sv @@
// kwm_back: base history memory, window tracking, rescan sequencer and output.
// Depends on kwm_pkg.
`default_nettype none
module kwm_back import kwm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned MAX_KMER   = MAX_KMER_DEF,
  parameter int unsigned POS_BITS   = POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        flush,
  input  wire logic [6:0]  window_size,
  input  wire logic [5:0]  kmer_length,
  input  wire logic        select_largest,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire kwm_item_t   q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [31:0]      result_value,
  output logic             result_last
);
  localparam int unsigned HIST_DEPTH = MAX_WINDOW + MAX_KMER - 1;
  localparam int unsigned HA = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned WB = $clog2(MAX_WINDOW + 1);
  localparam int unsigned KB = $clog2(MAX_KMER + 1);
  localparam int unsigned CB = POS_BITS + 1; // counts with a guard bit
  localparam logic [HA-1:0] DEPTH_M1 = HA'(HIST_DEPTH - 1);
  localparam logic [CB-1:0] SAT_LIM = (POS_BITS >= 32) ? CB'(33'hFFFF_FFFF)
                                                       : CB'((64'd1 << POS_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TRACK, S_CMP_RD, S_CMP, S_SCAN_NEXT, S_DECIDE, S_EMIT_POS, S_EMIT_CNT
  } state_t;

  state_t state;
  logic [2:0] hist [HIST_DEPTH];
  logic [2:0] rd_a, rd_b;

  logic [CB-1:0] base_count, best_pos, emitted, prev_best, idx_i, cand, scan_end;
  logic [HA-1:0] ptr_a, ptr_b, wr_ptr;
  logic [KB-1:0] t_cnt;
  logic          item_last;

  logic [WB-1:0] w_eff;
  logic [KB-1:0] k_eff;
  always_comb begin
    if (window_size == 7'd0) w_eff = WB'(1);
    else if (32'(window_size) > MAX_WINDOW) w_eff = WB'(MAX_WINDOW);
    else w_eff = WB'(window_size);
    if (kmer_length == 6'd0) k_eff = KB'(1);
    else if (32'(kmer_length) > MAX_KMER) k_eff = KB'(MAX_KMER);
    else k_eff = KB'(kmer_length);
  end

  function automatic logic [HA-1:0] inc_ptr(input logic [HA-1:0] p);
    return (p == DEPTH_M1) ? '0 : p + 1'b1;
  endfunction

  // position mod depth: values are bounded since only recent entries are read
  function automatic logic [HA-1:0] pos_ptr(input logic [HA-1:0] wp,
                                            input logic [CB-1:0] back);
    logic [HA:0] d;
    begin
      d = {1'b0, wp} - (HA+1)'(back);
      if (d[HA]) d = d + (HA+1)'(HIST_DEPTH);
      return d[HA-1:0];
    end
  endfunction

  logic [CB-1:0] cnt_inc, em_inc;
  assign cnt_inc = base_count + 1'b1;
  assign em_inc  = emitted + 1'b1;

  assign q_ready = (state == S_IDLE) && !flush;

  always_ff @(posedge clk) begin
    rd_a <= hist[ptr_a];
    rd_b <= hist[ptr_b];
    if (state == S_IDLE && q_valid && q_item.has_base && !flush) begin
      hist[wr_ptr] <= q_item.code;
    end
  end

  logic [CB-1:0] sat_v;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      state      <= S_IDLE;
      base_count <= '0;
      best_pos   <= '0;
      emitted    <= '0;
      wr_ptr     <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item_last <= q_item.last;
            if (q_item.has_base) begin
              base_count <= cnt_inc;
              wr_ptr     <= inc_ptr(wr_ptr);
              state      <= S_TRACK;
            end else begin
              // skipped byte: no new k-mer, only the end of sequence matters
              state <= S_DECIDE;
              prev_best <= best_pos;
              idx_i <= '1;
            end
          end
        end
        S_TRACK: begin
          prev_best <= best_pos;
          if (base_count < CB'(k_eff)) begin
            idx_i <= '1;
            state <= S_DECIDE;
          end else begin
            idx_i <= base_count - CB'(k_eff);
            if (base_count == CB'(k_eff)) begin
              best_pos <= '0;
              state    <= S_DECIDE;
            end else if (base_count - CB'(k_eff) - best_pos >= CB'(w_eff)) begin
              best_pos <= base_count - CB'(k_eff) - CB'(w_eff) + 1'b1;
              cand     <= base_count - CB'(k_eff) - CB'(w_eff) + 2'd2;
              scan_end <= base_count - CB'(k_eff);
              state    <= (w_eff == WB'(1)) ? S_DECIDE : S_SCAN_NEXT;
            end else begin
              cand     <= base_count - CB'(k_eff);
              scan_end <= base_count - CB'(k_eff);
              state    <= S_SCAN_NEXT;
            end
          end
        end
        S_SCAN_NEXT: begin
          // point both reads at the first base of best and candidate
          ptr_a <= pos_ptr(wr_ptr, base_count - best_pos);
          ptr_b <= pos_ptr(wr_ptr, base_count - cand);
          t_cnt <= '0;
          state <= S_CMP_RD;
        end
        S_CMP_RD: begin
          ptr_a <= inc_ptr(ptr_a);
          ptr_b <= inc_ptr(ptr_b);
          state <= S_CMP;
        end
        S_CMP: begin
          // one base per cycle; rd_a/rd_b hold base t
          priority if (rd_a == CODE_N || (rd_b != CODE_N &&
              ((rd_b > rd_a && select_largest) || (rd_b < rd_a && !select_largest)))) begin
            best_pos <= cand;
            state    <= (cand == scan_end) ? S_DECIDE : S_SCAN_NEXT;
            cand     <= cand + 1'b1;
          end else if (rd_b == CODE_N || rd_b != rd_a || t_cnt == k_eff - 1'b1) begin
            state <= (cand == scan_end) ? S_DECIDE : S_SCAN_NEXT;
            cand  <= cand + 1'b1;
          end else begin
            t_cnt <= t_cnt + 1'b1;
            ptr_a <= inc_ptr(ptr_a);
            ptr_b <= inc_ptr(ptr_b);
          end
        end
        S_DECIDE: begin
          if (idx_i != '1 && (idx_i + 1'b1 == CB'(w_eff) ||
              (idx_i >= CB'(w_eff) && best_pos != prev_best)) && base_count != '0) begin
            result_kind  <= RESULT_POS;
            result_value <= 32'(sat_v);
            result_last  <= !item_last;
            emitted      <= em_inc;
            out_valid    <= 1'b1;
            state        <= S_EMIT_POS;
          end else if (item_last) begin
            if (emitted != '0) begin
              result_kind  <= RESULT_COUNT;
              result_value <= 32'((emitted > SAT_LIM) ? SAT_LIM : emitted);
              result_last  <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_EMIT_CNT;
            end else begin
              state <= S_IDLE;
            end
            base_count <= '0;
            best_pos   <= '0;
            emitted    <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_POS: begin
          if (out_ready) begin
            if (item_last) begin
              result_kind  <= RESULT_COUNT;
              result_value <= 32'((emitted > SAT_LIM) ? SAT_LIM : emitted);
              result_last  <= 1'b1;
              base_count   <= '0;
              best_pos     <= '0;
              emitted      <= '0;
              state        <= S_EMIT_CNT;
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        S_EMIT_CNT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sat_v = (best_pos > SAT_LIM) ? SAT_LIM : best_pos;
endmodule
`default_nettype wire

@@ hdl/kmer_window_minimizer.sv @@
// kmer_window_minimizer: top level, configuration registers and the two halves.
// Depends on kwm_pkg, kwm_front and kwm_back.
`default_nettype none
// Window minimizer sampling over a stream of ASCII characters. The front
// classifies each beat (skip bytes up to space, map ACGTU to codes, rest to
// N) into a two-entry queue; the back writes the base history memory and
// tracks the best k-mer of the window. A base whose k-mer only meets the
// current best is compared against it one history base per cycle; when the
// best leaves the window the back rescans it. Each result beat holds the
// back until taken. Any configuration write to a valid index aborts the
// current sequence.
module kmer_window_minimizer import kwm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned MAX_KMER   = MAX_KMER_DEF,
  parameter int unsigned POS_BITS   = POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        seq_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [31:0]      result_value,
  output logic             result_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [6:0] window_size;
  logic [5:0] kmer_length;
  logic       select_largest;
  logic       flush;
  logic       q_valid, q_ready;
  kwm_item_t  q_item;

  assign cfg_ready = 1'b1;

  // hit on any valid register index; drop the sequence in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= 7'd10;
      kmer_length    <= 6'd15;
      select_largest <= 1'b0;
      flush          <= 1'b0;
    end else begin
      flush <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW: begin
            window_size <= cfg_data[6:0];
            flush       <= 1'b1;
          end
          REG_KMER: begin
            kmer_length <= cfg_data[5:0];
            flush       <= 1'b1;
          end
          REG_LARGEST: begin
            select_largest <= cfg_data[0];
            flush          <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  kwm_front u_front (
    .clk(clk), .rst(rst), .flush(flush),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_byte(char_byte), .seq_end(seq_end),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  kwm_back #(
    .MAX_WINDOW(MAX_WINDOW), .MAX_KMER(MAX_KMER), .POS_BITS(POS_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .flush(flush),
    .window_size(window_size), .kmer_length(kmer_length),
    .select_largest(select_largest),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .result_value(result_value),
    .result_last(result_last)
  );
endmodule
`default_nettype wire
